@@ rtl/core/mwem_pkg.sv @@
// ----------------------------------------------------------------------------
// mwem_pkg
// Types and constants shared by the Microwire EEPROM master modules.
// ----------------------------------------------------------------------------
package mwem_pkg;

    localparam int ADDR_W   = 10;
    localparam int DATA_W   = 16;
    localparam int PREFIX_W = 3;
    localparam int SHORT_OP_W = PREFIX_W + 2;

    // Frame lengths in bit clocks.
    localparam int LONG_LEN  = PREFIX_W + ADDR_W + DATA_W;
    localparam int SHORT_LEN = PREFIX_W + ADDR_W;
    localparam int BITS_W    = $clog2(LONG_LEN + 1);

    localparam logic [PREFIX_W-1:0]   OP_READ  = 3'h6;
    localparam logic [PREFIX_W-1:0]   OP_WRITE = 3'h5;
    localparam logic [SHORT_OP_W-1:0] OP_EWEN  = 5'h13;
    localparam logic [SHORT_OP_W-1:0] OP_EWDS  = 5'h10;

    // Short frames are held left aligned in the shift register.
    localparam logic [LONG_LEN-1:0] FRAME_EWEN = {OP_EWEN, {(LONG_LEN - SHORT_OP_W){1'b0}}};
    localparam logic [LONG_LEN-1:0] FRAME_EWDS = {OP_EWDS, {(LONG_LEN - SHORT_OP_W){1'b0}}};

    localparam logic [15:0] POLL_LIMIT_RST = 16'd1000;

    // Input mode codes.
    localparam logic [2:0] MODE_CLOCK = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_EWEN  = 3'd3;
    localparam logic [2:0] MODE_EWDS  = 3'd4;

    // Command classes passed from the front to the back.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_EWEN  = 3'd3;
    localparam logic [2:0] CMD_EWDS  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUMMY   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              miso;
    } t_in_item;

    typedef struct packed {
        logic              chip_select;
        logic              mosi;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              miso;
    } t_cmd;

endpackage

@@ rtl/core/microwire_eeprom_master.sv @@
// ----------------------------------------------------------------------------
// microwire_eeprom_master
// Microwire serial EEPROM master, one serial bit clock per transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one bit clock and yields one result transfer with
// chip select, data-in and status for that clock. The block sustains one
// transfer per clock cycle unless the output stalls: a classified item passes
// through a queue of QUEUE_DEPTH entries to the sequencer, which updates its
// frame state and loads the output register in the same cycle. The input stays
// ready while the queue has room, so the output side may stall for QUEUE_DEPTH
// transfers before the input is held off. The user must write the poll limit
// through the configuration port only while no command sequence is in flight;
// the block itself does not enforce this.
module microwire_eeprom_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mwem_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mwem_pkg::t_out_item o_out_data
);

    logic [15:0]    r_poll_limit;
    mwem_pkg::t_cmd cls_cmd;
    mwem_pkg::t_cmd head_cmd;
    logic           head_valid;
    logic           head_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= mwem_pkg::POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_wdata;
        end
    end

    mwem_front u_front (
        .i_item (i_in_data),
        .o_cmd  (cls_cmd)
    );

    mwem_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_push_ready (o_in_ready),
        .i_push_data  (cls_cmd),
        .o_head_valid (head_valid),
        .o_head_data  (head_cmd),
        .i_pop        (head_pop)
    );

    mwem_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poll_limit (r_poll_limit),
        .i_cmd_valid  (head_valid),
        .i_cmd        (head_cmd),
        .o_cmd_pop    (head_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // A full queue can only occur while items wait for the sequencer.
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> head_valid)
        else $error("queue full without a head item");

    // Chip select and completion only appear inside a command sequence.
    a_cs_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.chip_select || o_out_data.done_res)
            |-> o_out_data.busy_res)
        else $error("chip select or done outside a sequence");

    // Read data is shown only on the finishing clock.
    a_rdata_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |-> o_out_data.read_data == '0)
        else $error("read data outside the finishing clock");

    // The sequencer only takes an item when the output register can hold it.
    a_pop_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_pop |-> head_valid && (!o_out_valid || i_out_ready))
        else $error("sequencer took an item it cannot deliver");

endmodule

@@ rtl/core/mwem_front.sv @@
// ----------------------------------------------------------------------------
// mwem_front
// Classifies an incoming bit-clock item into a command class.
// ----------------------------------------------------------------------------
module mwem_front (
    input  mwem_pkg::t_in_item i_item,
    output mwem_pkg::t_cmd     o_cmd
);

    always_comb begin
        o_cmd.address    = i_item.address;
        o_cmd.write_data = i_item.write_data;
        o_cmd.miso       = i_item.miso;
        unique case (i_item.mode)
            mwem_pkg::MODE_READ:  o_cmd.cmd = mwem_pkg::CMD_READ;
            mwem_pkg::MODE_WRITE: o_cmd.cmd = mwem_pkg::CMD_WRITE;
            mwem_pkg::MODE_EWEN:  o_cmd.cmd = mwem_pkg::CMD_EWEN;
            mwem_pkg::MODE_EWDS:  o_cmd.cmd = mwem_pkg::CMD_EWDS;
            // Plain bit clock and the unused codes start nothing.
            default:              o_cmd.cmd = mwem_pkg::CMD_NONE;
        endcase
    end

endmodule

@@ rtl/core/mwem_queue.sv @@
// ----------------------------------------------------------------------------
// mwem_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module mwem_queue #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  mwem_pkg::t_cmd  i_push_data,
    output logic            o_head_valid,
    output mwem_pkg::t_cmd  o_head_data,
    input  logic            i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    mwem_pkg::t_cmd   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head_data  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/core/mwem_back.sv @@
// ----------------------------------------------------------------------------
// mwem_back
// Command sequencer: drives the serial frames one bit clock per item and
// holds each result in an output register.
// ----------------------------------------------------------------------------
module mwem_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_poll_limit,
    input  logic                i_cmd_valid,
    input  mwem_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mwem_pkg::t_out_item o_out_data
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RD      = 4'd1;
    localparam logic [3:0] PH_RD_OFF  = 4'd2;
    localparam logic [3:0] PH_EN      = 4'd3;
    localparam logic [3:0] PH_EN_OFF  = 4'd4;
    localparam logic [3:0] PH_WEN     = 4'd5;
    localparam logic [3:0] PH_WEN_OFF = 4'd6;
    localparam logic [3:0] PH_WR      = 4'd7;
    localparam logic [3:0] PH_POLL    = 4'd8;
    localparam logic [3:0] PH_TO_BIT  = 4'd9;
    localparam logic [3:0] PH_TO_OFF  = 4'd10;
    localparam logic [3:0] PH_DS      = 4'd11;
    localparam logic [3:0] PH_DS_OFF  = 4'd12;

    localparam int LONG_LEN = mwem_pkg::LONG_LEN;
    localparam int DATA_W   = mwem_pkg::DATA_W;
    localparam int BITS_W   = mwem_pkg::BITS_W;

    logic [3:0]          r_phase;
    logic [LONG_LEN-1:0] r_shift;
    logic [LONG_LEN-1:0] r_pend;
    logic [BITS_W-1:0]   r_bits;
    logic [DATA_W:0]     r_cap;
    logic [15:0]         r_poll;
    logic [1:0]          r_sst;
    logic                r_out_valid;
    mwem_pkg::t_out_item r_out;

    logic [3:0]          n_phase;
    logic [LONG_LEN-1:0] n_shift;
    logic [LONG_LEN-1:0] n_pend;
    logic [BITS_W-1:0]   n_bits;
    logic [DATA_W:0]     n_cap;
    logic [15:0]         n_poll;
    logic [1:0]          n_sst;
    mwem_pkg::t_out_item n_out;

    logic                fire;
    logic [15:0]         poll_inc;

    // A new item is worked whenever the output register is free or draining.
    assign fire        = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop   = fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign poll_inc    = r_poll + 16'd1;

    always_comb begin
        logic [3:0]          ph;
        logic [LONG_LEN-1:0] sh;
        logic [BITS_W-1:0]   bits;
        logic                rejected;

        ph       = r_phase;
        sh       = r_shift;
        bits     = r_bits;
        rejected = 1'b0;
        n_pend   = r_pend;
        n_poll   = r_poll;
        n_sst    = r_sst;
        n_cap    = r_cap;
        n_out    = '0;

        // Command start: the accepting bit clock already drives the first bit.
        if (r_phase == PH_IDLE) begin
            unique case (i_cmd.cmd)
                mwem_pkg::CMD_READ: begin
                    ph    = PH_RD;
                    sh    = {mwem_pkg::OP_READ, i_cmd.address, {DATA_W{1'b0}}};
                    bits  = BITS_W'(mwem_pkg::LONG_LEN);
                    n_sst = mwem_pkg::ST_OK;
                end
                mwem_pkg::CMD_WRITE: begin
                    ph     = PH_WEN;
                    sh     = mwem_pkg::FRAME_EWEN;
                    bits   = BITS_W'(mwem_pkg::SHORT_LEN);
                    n_pend = {mwem_pkg::OP_WRITE, i_cmd.address, i_cmd.write_data};
                    n_poll = '0;
                    n_sst  = mwem_pkg::ST_OK;
                end
                mwem_pkg::CMD_EWEN: begin
                    ph    = PH_EN;
                    sh    = mwem_pkg::FRAME_EWEN;
                    bits  = BITS_W'(mwem_pkg::SHORT_LEN);
                    n_sst = mwem_pkg::ST_OK;
                end
                mwem_pkg::CMD_EWDS: begin
                    ph    = PH_DS;
                    sh    = mwem_pkg::FRAME_EWDS;
                    bits  = BITS_W'(mwem_pkg::SHORT_LEN);
                    n_sst = mwem_pkg::ST_OK;
                end
                default: begin
                end
            endcase
        end else begin
            rejected = (i_cmd.cmd != mwem_pkg::CMD_NONE);
        end

        n_phase         = ph;
        n_shift         = sh;
        n_bits          = bits;
        n_out.busy_res  = 1'b1;

        unique case (ph)
            PH_RD, PH_EN, PH_WEN, PH_WR, PH_DS: begin
                n_out.chip_select = 1'b1;
                n_out.mosi        = sh[LONG_LEN-1];
                n_shift           = {sh[LONG_LEN-2:0], 1'b0};
                n_cap             = {r_cap[DATA_W-1:0], i_cmd.miso};
                n_bits            = bits - BITS_W'(1);
                if (bits == BITS_W'(1)) begin
                    unique case (ph)
                        PH_RD:   n_phase = PH_RD_OFF;
                        PH_EN:   n_phase = PH_EN_OFF;
                        PH_WEN:  n_phase = PH_WEN_OFF;
                        PH_DS:   n_phase = PH_DS_OFF;
                        default: begin
                            n_phase = PH_POLL;
                            n_poll  = '0;
                        end
                    endcase
                end
            end
            PH_RD_OFF: begin
                n_out.done_res  = 1'b1;
                n_out.read_data = r_cap[DATA_W-1:0];
                // The dummy bit was sampled during the last address bit.
                n_out.status    = r_cap[DATA_W] ? mwem_pkg::ST_DUMMY : mwem_pkg::ST_OK;
                n_phase         = PH_IDLE;
            end
            PH_EN_OFF, PH_DS_OFF: begin
                n_out.done_res = 1'b1;
                n_out.status   = r_sst;
                n_phase        = PH_IDLE;
            end
            PH_WEN_OFF: begin
                n_shift = r_pend;
                n_bits  = BITS_W'(mwem_pkg::LONG_LEN);
                n_phase = PH_WR;
            end
            PH_POLL: begin
                n_out.chip_select = 1'b1;
                if (i_cmd.miso) begin
                    n_phase = PH_DS;
                    n_shift = mwem_pkg::FRAME_EWDS;
                    n_bits  = BITS_W'(mwem_pkg::SHORT_LEN);
                end else begin
                    n_poll = poll_inc;
                    // A limit of zero acts as one; a wrapped count also ends the poll.
                    if (poll_inc >= i_poll_limit || poll_inc == '0) begin
                        n_sst   = mwem_pkg::ST_TIMEOUT;
                        n_phase = PH_TO_BIT;
                    end
                end
            end
            PH_TO_BIT: begin
                n_out.chip_select = 1'b1;
                n_phase           = PH_TO_OFF;
            end
            PH_TO_OFF: begin
                n_phase = PH_DS;
                n_shift = mwem_pkg::FRAME_EWDS;
                n_bits  = BITS_W'(mwem_pkg::SHORT_LEN);
            end
            default: begin
                n_phase        = PH_IDLE;
                n_out.busy_res = 1'b0;
            end
        endcase

        if (rejected && !n_out.done_res) begin
            n_out.status = mwem_pkg::ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_shift     <= '0;
            r_bits      <= '0;
            r_poll      <= '0;
            r_cap       <= '0;
            r_sst       <= mwem_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_bits      <= n_bits;
            r_poll      <= n_poll;
            r_cap       <= n_cap;
            r_sst       <= n_sst;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pend <= n_pend;
            r_out  <= n_out;
        end
    end

endmodule
